@@ rtl/bcdld_pkg.sv @@
// shared constants and control types for the bcd latched display driver
package bcdld_pkg;

    localparam int VALUE_W            = 32;
    localparam int DIGIT_W            = 4;
    localparam int SEL_W              = 3;
    localparam int CNT_W              = 4;
    localparam int BITCNT_W           = $clog2(VALUE_W);
    localparam int DEFAULT_MAX_DIGITS = 8;

    localparam logic [CNT_W-1:0]   DIGIT_COUNT_RESET = 4'd4;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT      = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD        = 4'd3;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

endpackage

@@ rtl/bcd_latched_display_driver.sv @@
// top level of the bcd latched display driver
// Takes a 32-bit unsigned value, converts it to decimal with a shift-add-3
// (double dabble) converter that handles one input bit per clock, keeps the
// lowest digit_count digits (zero counts as one, anything above MAX_DIGITS
// counts as MAX_DIGITS) and sends one output beat per digit, most significant
// first. Each beat carries the bcd code for the decoder data bus, the latch
// select (0 for the most significant digit, counted modulo 8) and last_digit
// on the final beat of the run. One value takes a capture step, 32 conversion
// steps in the one-bit-per-clock converter, and then one beat per digit as
// the output stall allows; the digit count resets to 4. The next value is
// accepted as soon as the last digit is in the output register, while that
// beat may still be waiting. digit_count is written through its own
// valid/ready port, always ready, and should only be changed while no value
// is in flight.
module bcd_latched_display_driver
    import bcdld_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // value input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    // digit output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIGIT_W-1:0] bcd_digit,
    output logic [SEL_W-1:0]   digit_select,
    output logic               last_digit,
    // digit count register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CNT_W-1:0]   digit_count
);

    cmd_t cmd;
    sts_t sts;

    // register writes never wait
    assign cfg_ready = 1'b1;

    // state machine: capture, 32 conversion steps, then one beat per digit
    bcdld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // converter lanes, digit pointer and output payload register
    bcdld_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (digit_count),
        .value        (value),
        .cmd          (cmd),
        .sts          (sts),
        .bcd_digit    (bcd_digit),
        .digit_select (digit_select),
        .last_digit   (last_digit)
    );

endmodule

@@ rtl/bcdld_dpath.sv @@
// datapath: shift-add-3 converter, digit lanes, digit pointer and output payload
module bcdld_dpath
    import bcdld_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic [VALUE_W-1:0]   value,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic [DIGIT_W-1:0]   bcd_digit,
    output logic [SEL_W-1:0]     digit_select,
    output logic                 last_digit
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [CNT_W-1:0]   digit_count_reg;
    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [DIGIT_W-1:0] bcd_digit_reg;
    logic [SEL_W-1:0]   digit_select_reg;
    logic               last_digit_reg;

    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   eff_digits;
    logic [IDX_W-1:0]   pos_init;
    logic [DIGIT_W-1:0] cur_digit;

    // add 3 to every lane that is 5 or more before the shift
    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT)
                bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            else
                bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
        end
    end

    // zero means one digit, more than the lanes saturates
    always_comb
    begin
        if (digit_count_reg == '0)
            eff_digits = CNT_W'(1);
        else if (digit_count_reg > CNT_W'(MAX_DIGITS))
            eff_digits = CNT_W'(MAX_DIGITS);
        else
            eff_digits = digit_count_reg;
    end

    assign pos_init  = IDX_W'(eff_digits - CNT_W'(1));
    assign cur_digit = bcd_reg[pos_reg*DIGIT_W +: DIGIT_W];
    assign sts.last  = (pos_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_count_reg <= DIGIT_COUNT_RESET;
        else if (cfg_we)
            digit_count_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
            pos_reg <= pos_init;
            sel_reg <= '0;
        end
        else if (cmd.shift)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
        else if (cmd.emit)
        begin
            bcd_digit_reg    <= cur_digit;
            digit_select_reg <= sel_reg;
            last_digit_reg   <= sts.last;
            pos_reg          <= pos_reg - IDX_W'(1);
            sel_reg          <= sel_reg + SEL_W'(1);
        end
    end

    assign bcd_digit    = bcd_digit_reg;
    assign digit_select = digit_select_reg;
    assign last_digit   = last_digit_reg;

endmodule

@@ rtl/bcdld_ctrl.sv @@
// controller: sequences capture, conversion steps and digit beats
module bcdld_ctrl
    import bcdld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic                out_valid_reg;
    logic                out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.load  = in_valid;
            S_CONV:  cmd.shift = 1'b1;
            S_EMIT:  cmd.emit  = out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    bit_cnt_reg <= '0;
                    if (in_valid)
                        state_reg <= S_CONV;
                end
                S_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + BITCNT_W'(1);
                    if (bit_cnt_reg == BITCNT_W'(VALUE_W - 1))
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (cmd.emit && sts.last)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
